// ===== rtl/mpc_pkg.sv =====
`default_nettype none

package mpc_pkg;

    typedef enum logic [3:0] {
        CMD_DATA_ENTRY = 4'd0,
        CMD_NRPN       = 4'd1,
        CMD_RPN_LSB    = 4'd2,
        CMD_RPN_MSB    = 4'd3,
        CMD_PEDAL      = 4'd4,
        CMD_BEND       = 4'd5,
        CMD_MOD        = 4'd6,
        CMD_VOL        = 4'd7,
        CMD_EXPR       = 4'd8,
        CMD_PAN        = 4'd9,
        CMD_CTL_RESET  = 4'd10,
        CMD_PART_RESET = 4'd11,
        CMD_KEY        = 4'd12
    } t_cmd;

    typedef enum logic {
        CFG_KEY_SHIFT  = 1'b0,
        CFG_BEND_RANGE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [13:0] value;
    } t_mpc_in;

    typedef struct packed {
        logic signed [14:0] pitch_bend;
        logic [6:0]         modulation_level;
        logic [6:0]         volume_level;
        logic [6:0]         expression_level;
        logic [3:0]         pan_position;
        logic [4:0]         bend_semitones;
        logic [6:0]         translated_key;
        logic               pedal_held;
        logic               release_held;
        logic               sound_off;
    } t_mpc_out;

    localparam logic [4:0]  BEND_MAX_SEMIS   = 5'd24;
    localparam logic [9:0]  BEND_STEP        = 10'd683;
    localparam logic [5:0]  KEY_SHIFT_RST    = 6'd24;
    localparam logic [4:0]  BEND_RANGE_RST   = 5'd12;
    localparam logic [15:0] PARAM_NONE       = 16'hFFFF;
    localparam logic [6:0]  LEVEL_RST        = 7'd100;
    localparam logic [3:0]  PAN_RST          = 4'd7;
    localparam logic [6:0]  PEDAL_THRESH     = 7'd64;
    localparam logic [7:0]  KEY_LOW          = 8'd36;
    localparam logic [7:0]  KEY_HIGH         = 8'd132;
    localparam logic [7:0]  KEY_OCTAVE       = 8'd12;
    localparam logic [7:0]  KEY_BIAS         = 8'd24;
    // x*100/127 == (x*100*8257) >> 20 for all 7-bit x
    localparam logic [19:0] LEVEL_RECIP      = 20'd825700;
    // x*8/68 == (x*482) >> 12 for all 7-bit x
    localparam logic [8:0]  PAN_RECIP        = 9'd482;

    function automatic logic [4:0] f_clamp_range(input logic [6:0] x);
        return (x > 7'(BEND_MAX_SEMIS)) ? BEND_MAX_SEMIS : x[4:0];
    endfunction

    function automatic logic [14:0] f_bend_step(input logic [4:0] range);
        logic [14:0] p;
        p = 15'(range) * 15'(BEND_STEP);
        return p;
    endfunction

    function automatic logic [6:0] f_level(input logic [6:0] x);
        logic [26:0] p;
        p = 27'(x) * 27'(LEVEL_RECIP);
        return p[26:20];
    endfunction

    function automatic logic [3:0] f_pan(input logic [6:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'(PAN_RECIP);
        return p[15:12];
    endfunction

    function automatic logic [6:0] f_fold_key(input logic [6:0] key, input logic [5:0] shift);
        logic [7:0] k;
        logic [7:0] d;
        k = 8'(key) + 8'(shift);
        d = 8'd0;
        if (k < KEY_LOW) begin
            d = KEY_LOW - k;
            if (d <= KEY_OCTAVE)               k = k + KEY_OCTAVE;
            else if (d <= 8'(2 * KEY_OCTAVE))  k = k + 8'(2 * KEY_OCTAVE);
            else                               k = k + 8'(3 * KEY_OCTAVE);
        end else if (k > KEY_HIGH) begin
            d = k - KEY_HIGH;
            if (d <= KEY_OCTAVE)               k = k - KEY_OCTAVE;
            else if (d <= 8'(2 * KEY_OCTAVE))  k = k - 8'(2 * KEY_OCTAVE);
            else if (d <= 8'(3 * KEY_OCTAVE))  k = k - 8'(3 * KEY_OCTAVE);
            else if (d <= 8'(4 * KEY_OCTAVE))  k = k - 8'(4 * KEY_OCTAVE);
            else                               k = k - 8'(5 * KEY_OCTAVE);
        end
        k = k - KEY_BIAS;
        return k[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mpc_in_stage.sv =====
`default_nettype none

module mpc_in_stage
    import mpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_mpc_in i_in_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_mpc_in      o_data
);

    logic    r_valid;
    t_mpc_in r_data;

    assign o_in_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_data <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mpc_ctl_core.sv =====
`default_nettype none

module mpc_ctl_core
    import mpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_mpc_in    i_data,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_index,
    input  wire logic [5:0] i_cfg_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_mpc_out        o_out_data
);

    logic [5:0]         r_key_shift;
    logic [15:0]        r_param;
    logic               r_nrpn;
    logic [4:0]         r_range;
    logic [14:0]        r_bend_step;
    logic signed [14:0] r_bend;
    logic [6:0]         r_mod;
    logic [6:0]         r_expr;
    logic [6:0]         r_vol;
    logic [3:0]         r_pan;
    logic               r_pedal;
    logic               r_out_valid;
    t_mpc_out           r_out;

    logic [15:0]        n_param;
    logic               n_nrpn;
    logic [4:0]         n_range;
    logic signed [14:0] n_bend;
    logic [6:0]         n_mod;
    logic [6:0]         n_expr;
    logic [6:0]         n_vol;
    logic [3:0]         n_pan;
    logic               n_pedal;
    t_mpc_out           n_out;

    logic               fire;
    logic [6:0]         v7;
    logic               pressed;
    logic [6:0]         key_out;
    logic               rel;
    logic               soff;
    logic signed [13:0] bend_off;
    logic signed [29:0] bend_prod;

    assign o_ready     = !r_out_valid || i_out_ready;
    assign fire        = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign v7      = i_data.value[6:0];
    assign pressed = (v7 >= PEDAL_THRESH);
    // value - 8192 as a 14-bit signed number
    assign bend_off  = {~i_data.value[13], i_data.value[12:0]};
    assign bend_prod = 30'(bend_off) * $signed({15'd0, r_bend_step});

    always_comb begin
        n_param = r_param;
        n_nrpn  = r_nrpn;
        n_range = r_range;
        n_bend  = r_bend;
        n_mod   = r_mod;
        n_expr  = r_expr;
        n_vol   = r_vol;
        n_pan   = r_pan;
        n_pedal = r_pedal;
        key_out = 7'd0;
        rel     = 1'b0;
        soff    = 1'b0;
        case (t_cmd'(i_data.cmd))
            CMD_DATA_ENTRY: begin
                if (!r_nrpn && r_param == 16'd0) n_range = f_clamp_range(v7);
            end
            CMD_NRPN: begin
                n_nrpn = 1'b1;
            end
            CMD_RPN_LSB: begin
                n_nrpn  = 1'b0;
                n_param = {r_param[15:8], 1'b0, v7};
            end
            CMD_RPN_MSB: begin
                n_nrpn  = 1'b0;
                n_param = {1'b0, v7, r_param[7:0]};
            end
            CMD_PEDAL: begin
                rel     = r_pedal && !pressed;
                n_pedal = pressed;
            end
            CMD_BEND: begin
                // arithmetic shift rounds toward minus infinity
                n_bend = bend_prod[28:14];
            end
            CMD_MOD: begin
                n_mod = v7;
            end
            CMD_VOL: begin
                n_vol = f_level(v7);
            end
            CMD_EXPR: begin
                n_expr = f_level(v7);
            end
            CMD_PAN: begin
                n_pan = f_pan(v7);
            end
            CMD_CTL_RESET: begin
                n_mod   = 7'd0;
                n_expr  = LEVEL_RST;
                n_bend  = 15'sd0;
                rel     = r_pedal;
                n_pedal = 1'b0;
            end
            CMD_PART_RESET: begin
                n_mod   = 7'd0;
                n_expr  = LEVEL_RST;
                n_bend  = 15'sd0;
                rel     = r_pedal;
                n_pedal = 1'b0;
                soff    = 1'b1;
                n_param = PARAM_NONE;
            end
            CMD_KEY: begin
                key_out = f_fold_key(v7, r_key_shift);
            end
            default: begin
            end
        endcase

        n_out.pitch_bend       = n_bend;
        n_out.modulation_level = n_mod;
        n_out.volume_level     = n_vol;
        n_out.expression_level = n_expr;
        n_out.pan_position     = n_pan;
        n_out.bend_semitones   = n_range;
        n_out.translated_key   = key_out;
        n_out.pedal_held       = n_pedal;
        n_out.release_held     = rel;
        n_out.sound_off        = soff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_shift <= KEY_SHIFT_RST;
            r_param     <= PARAM_NONE;
            r_nrpn      <= 1'b0;
            r_range     <= BEND_RANGE_RST;
            r_bend_step <= f_bend_step(BEND_RANGE_RST);
            r_bend      <= 15'sd0;
            r_mod       <= 7'd0;
            r_expr      <= LEVEL_RST;
            r_vol       <= LEVEL_RST;
            r_pan       <= PAN_RST;
            r_pedal     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (fire) begin
                r_param     <= n_param;
                r_nrpn      <= n_nrpn;
                r_range     <= n_range;
                r_bend_step <= f_bend_step(n_range);
                r_bend      <= n_bend;
                r_mod       <= n_mod;
                r_expr      <= n_expr;
                r_vol       <= n_vol;
                r_pan       <= n_pan;
                r_pedal     <= n_pedal;
            end
            // config must only arrive while idle; the block itself does not enforce this
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_KEY_SHIFT: begin
                        r_key_shift <= i_cfg_data;
                    end
                    CFG_BEND_RANGE: begin
                        r_range     <= f_clamp_range({2'b00, i_cfg_data[4:0]});
                        r_bend_step <= f_bend_step(f_clamp_range({2'b00, i_cfg_data[4:0]}));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/midi_part_controller_state.sv =====
// A beat is registered first in the input stage and then in the output register of the core.
// Throughput: one beat per cycle while the output is not stalled; ready passes straight through both registers.
// The bend scale product is kept in a register next to the range, so bend uses
// one 14x15 multiply per beat.
// Reset: synchronous, active low; restores all controller state to its defaults.
`default_nettype none

module midi_part_controller_state
    import mpc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_mpc_in    i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_mpc_out        o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [5:0] i_cfg_data
);

    logic    stg_valid;
    logic    stg_ready;
    t_mpc_in stg_data;

    assign o_cfg_ready = 1'b1;

    mpc_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_valid    (stg_valid),
        .i_ready    (stg_ready),
        .o_data     (stg_data)
    );

    mpc_ctl_core u_ctl_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid),
        .o_ready     (stg_ready),
        .i_data      (stg_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== bench/midi_part_controller_state_tb.sv =====
`timescale 1ns / 100ps

module midi_part_controller_state_tb;
    import mpc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_mpc_in    i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_mpc_out   o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [5:0] i_cfg_data;

    midi_part_controller_state DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Controller state as the block should hold it
    logic [5:0]         cur_key_shift;
    logic [15:0]        cur_param;
    logic               cur_nrpn;
    logic [4:0]         cur_range;
    logic signed [14:0] cur_bend;
    logic [6:0]         cur_mod;
    logic [6:0]         cur_vol;
    logic [6:0]         cur_expr;
    logic [3:0]         cur_pan;
    logic               cur_pedal;

    t_mpc_out expected_q[$];
    t_mpc_out want;

    int  events_in;
    int  results_seen;
    int  reg_writes;
    int  mismatches;
    int  holdoffs_done;
    bit  sender_eager;
    bit  receiver_eager;
    bit  hold_off_req;

    function automatic logic [4:0] clip_semitones(input logic [6:0] x);
        return (x > 7'd24) ? 5'd24 : x[4:0];
    endfunction

    function automatic logic pedal_update(input logic pressed);
        logic released;
        released  = cur_pedal && !pressed;
        cur_pedal = pressed;
        return released;
    endfunction

    function automatic t_mpc_out controller_step(input t_mpc_in beat);
        t_mpc_out   r;
        logic [6:0] v7;
        int         k;
        longint     prod;
        r  = '0;
        v7 = beat.value[6:0];
        case (beat.cmd)
            CMD_DATA_ENTRY: begin
                if (!cur_nrpn && cur_param == 16'h0000)
                    cur_range = clip_semitones(v7);
            end
            CMD_NRPN: cur_nrpn = 1'b1;
            CMD_RPN_LSB: begin
                cur_nrpn  = 1'b0;
                cur_param = {cur_param[15:8], 1'b0, v7};
            end
            CMD_RPN_MSB: begin
                cur_nrpn  = 1'b0;
                cur_param = {1'b0, v7, cur_param[7:0]};
            end
            CMD_PEDAL: r.release_held = pedal_update(v7 >= 7'd64);
            CMD_BEND: begin
                prod = (longint'(beat.value) - 64'sd8192) * longint'(cur_range) * 64'sd683;
                // arithmetic shift rounds toward minus infinity
                cur_bend = 15'(prod >>> 14);
            end
            CMD_MOD:  cur_mod  = v7;
            CMD_VOL:  cur_vol  = 7'((int'(v7) * 100) / 127);
            CMD_EXPR: cur_expr = 7'((int'(v7) * 100) / 127);
            CMD_PAN:  cur_pan  = 4'((int'(v7) * 8) / 68);
            CMD_CTL_RESET, CMD_PART_RESET: begin
                cur_mod  = 7'd0;
                cur_expr = 7'd100;
                cur_bend = '0;
                r.release_held = pedal_update(1'b0);
                if (beat.cmd == CMD_PART_RESET) begin
                    r.sound_off = 1'b1;
                    cur_param   = 16'hFFFF;
                end
            end
            CMD_KEY: begin
                k = int'(v7) + int'(cur_key_shift);
                if (k < 36)
                    k = k + 12 * ((36 - k + 11) / 12);
                else if (k > 132)
                    k = k - 12 * ((k - 132 + 11) / 12);
                r.translated_key = 7'(k - 24);
            end
            default: ;
        endcase
        r.pitch_bend       = cur_bend;
        r.modulation_level = cur_mod;
        r.volume_level     = cur_vol;
        r.expression_level = cur_expr;
        r.pan_position     = cur_pan;
        r.bend_semitones   = cur_range;
        r.pedal_held       = cur_pedal;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Prediction on each accepted input beat, checking on each accepted result beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_key_shift = 6'd24;
            cur_param     = 16'hFFFF;
            cur_nrpn      = 1'b0;
            cur_range     = 5'd12;
            cur_bend      = '0;
            cur_mod       = 7'd0;
            cur_vol       = 7'd100;
            cur_expr      = 7'd100;
            cur_pan       = 4'd7;
            cur_pedal     = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                reg_writes++;
                if (i_cfg_index == CFG_KEY_SHIFT) begin
                    cur_key_shift = i_cfg_data;
                end else begin
                    cur_range = clip_semitones({2'b00, i_cfg_data[4:0]});
                end
            end
            if (i_in_valid && o_in_ready) begin
                events_in++;
                expected_q.insert(expected_q.size(), controller_step(i_in_data));
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, o_out_data);
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    compare_field("pitch_bend", $signed(want.pitch_bend),
                                  $signed(o_out_data.pitch_bend));
                    compare_field("modulation_level", want.modulation_level,
                                  o_out_data.modulation_level);
                    compare_field("volume_level", want.volume_level,
                                  o_out_data.volume_level);
                    compare_field("expression_level", want.expression_level,
                                  o_out_data.expression_level);
                    compare_field("pan_position", want.pan_position,
                                  o_out_data.pan_position);
                    compare_field("bend_semitones", want.bend_semitones,
                                  o_out_data.bend_semitones);
                    compare_field("translated_key", want.translated_key,
                                  o_out_data.translated_key);
                    compare_field("pedal_held", want.pedal_held, o_out_data.pedal_held);
                    compare_field("release_held", want.release_held,
                                  o_out_data.release_held);
                    compare_field("sound_off", want.sound_off, o_out_data.sound_off);
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    initial begin : receiver
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                holdoffs_done++;
            end
            if (receiver_eager) begin
                i_out_ready = 1'b1;
                stall_left  = 0;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left  = gap_length();
            end
        end
    end

    function automatic logic [13:0] random_value();
        case ($urandom_range(0, 9))
            0: return 14'h0000;
            1: return 14'h3FFF;
            2: return 14'(($urandom_range(0, 127) << 7) | $urandom_range(63, 64));
            3: return 14'($urandom_range(8188, 8196));
            default: return 14'($urandom_range(0, 16383));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    // Valid is left high so back-to-back beats need no drop.
    task automatic send_event(input logic [3:0] cmd, input logic [13:0] value);
        int gap;
        gap = sender_eager ? 0 : gap_length();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = {cmd, value};
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [5:0] data);
        drain();
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_event();
        logic [13:0] hi;
        int          pick;
        pick = $urandom_range(0, 99);
        hi   = 14'($urandom_range(0, 127) << 7);
        if (pick < 25) begin
            // select RPN 0, set the range, then bend with it; sometimes spoiled
            send_event(CMD_RPN_MSB, ($urandom_range(0, 3) == 0) ? random_value() : hi);
            send_event(CMD_RPN_LSB, ($urandom_range(0, 3) == 0) ? random_value() : hi);
            if ($urandom_range(0, 5) == 0)
                send_event(CMD_NRPN, random_value());
            send_event(CMD_DATA_ENTRY, ($urandom_range(0, 3) == 0) ? random_value() :
                       (hi | 14'($urandom_range(0, 30))));
            send_event(CMD_BEND, random_value());
        end else if (pick < 40) begin
            send_event(CMD_KEY, random_value());
        end else if (pick < 44) begin
            send_event(4'($urandom_range(13, 15)), random_value());
        end else begin
            send_event(4'($urandom_range(0, 12)), random_value());
        end
    endtask

    task automatic test_directed_controls();
        send_event(CMD_MOD, 14'h3FFF);
        send_event(CMD_MOD, 14'h0000);
        send_event(CMD_VOL, 14'h007F);
        send_event(CMD_VOL, 14'h3F80);
        send_event(CMD_EXPR, 14'h3FFF);
        send_event(CMD_PAN, 14'h007F);
        send_event(CMD_PAN, 14'h0000);
        send_event(CMD_BEND, 14'h3FFF);
        send_event(CMD_BEND, 14'h0000);
        send_event(CMD_BEND, 14'd8192);
        // pedal threshold both ways, release pulses from pedal, ctl reset, part reset
        send_event(CMD_PEDAL, 14'd64);
        send_event(CMD_PEDAL, 14'd63);
        send_event(CMD_PEDAL, 14'h3FFF);
        send_event(CMD_CTL_RESET, 14'h0000);
        send_event(CMD_PEDAL, 14'd100);
        send_event(CMD_PART_RESET, 14'h0000);
        drain();
    endtask

    task automatic test_directed_rpn_keys();
        send_event(CMD_RPN_LSB, 14'h3F80);
        send_event(CMD_RPN_MSB, 14'h0000);
        send_event(CMD_DATA_ENTRY, 14'h007F);   // range clamps at 24
        send_event(CMD_NRPN, 14'h0000);
        send_event(CMD_DATA_ENTRY, 14'd5);      // ignored while NRPN selected
        send_event(CMD_RPN_LSB, 14'h0000);
        send_event(CMD_DATA_ENTRY, 14'd2);
        send_event(CMD_KEY, 14'h0000);
        send_event(CMD_KEY, 14'h007F);
        send_event(4'd13, 14'h3FFF);
        send_event(4'd15, 14'h1234);
        drain();
    endtask

    task automatic test_config_extremes();
        logic [5:0] shifts [4];
        logic [5:0] ranges [4];
        shifts = '{6'd0, 6'd48, 6'd63, 6'd24};
        ranges = '{6'd0, 6'd24, 6'h3F, 6'd12};
        for (int i = 0; i < 4; i++) begin
            write_reg(CFG_KEY_SHIFT, shifts[i]);
            write_reg(CFG_BEND_RANGE, ranges[i]);
            send_event(CMD_KEY, 14'h0000);
            send_event(CMD_KEY, 14'h007F);
            send_event(CMD_KEY, random_value());
            send_event(CMD_BEND, 14'h0000);
            send_event(CMD_BEND, 14'h3FFF);
            send_event(CMD_PEDAL, random_value());
        end
        drain();
    endtask

    task automatic test_pause_for_drain();
        repeat (20) random_event();
        drain();
        repeat (20) random_event();
        drain();
    endtask

    task automatic test_receiver_hold_off();
        sender_eager = 1'b1;
        hold_off_req = 1'b1;
        repeat (40) send_event(4'($urandom_range(0, 12)), random_value());
        sender_eager = 1'b0;
        drain();
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_KEY_SHIFT, 6'($urandom_range(0, 63)));
            write_reg(CFG_BEND_RANGE, 6'($urandom_range(0, 63)));
            // first phase runs with no idling on either side
            sender_eager   = (phase == 0);
            receiver_eager = (phase == 0);
            target = events_in + 200;
            while (events_in < target) random_event();
        end
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = 1'b0;
        i_cfg_data     = '0;
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
        hold_off_req   = 1'b0;
        events_in      = 0;
        results_seen   = 0;
        reg_writes     = 0;
        mismatches     = 0;
        holdoffs_done  = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_controls();
        test_directed_rpn_keys();
        test_config_extremes();
        test_pause_for_drain();
        test_receiver_hold_off();
        test_random_traffic();
        drain();

        $display("Run: %0d controller events, %0d results checked, %0d register writes",
                 events_in, results_seen, reg_writes);
        $display("Covered RPN/NRPN data entry, pedal pulses, key folding at %s, %0d hold-off(s)",
                 "shift extremes", holdoffs_done);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== midi_part_controller_state.f =====
rtl/mpc_pkg.sv
rtl/mpc_in_stage.sv
rtl/mpc_ctl_core.sv
rtl/midi_part_controller_state.sv
bench/midi_part_controller_state_tb.sv
